// ===== hw/rtl/e2c_pkg.sv =====
// e2c_pkg: constants, tables and types shared by the epoch to calendar pipeline
// no dependencies; imported by e2c_day_split and epoch_seconds_to_calendar
package e2c_pkg;

  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned DayLowBits = 7;      // 86400 = 2^7 * 675
  localparam int unsigned DayOdd     = 675;
  localparam int unsigned DaysQuad   = 1461;
  localparam int unsigned DaysYear   = 365;
  localparam int unsigned SecsHour   = 3600;
  localparam int unsigned SecsMin    = 60;
  localparam int unsigned EpochYear  = 70;
  localparam int unsigned EpochWday  = 4;

  // reciprocal constants: floor(2^34/675) is corrected later,
  // the others are ceiling values that are exact over their input ranges
  localparam logic [24:0] RecipOdd   = 25'd25451658;  // >> 34
  localparam logic [15:0] RecipQuad  = 16'd45934;     // >> 26, days / 1461
  localparam logic [15:0] RecipSeven = 16'd37450;     // >> 18, / 7
  localparam logic [12:0] RecipHour  = 13'd4661;      // >> 20, (sod >> 4) / 225
  localparam logic [10:0] RecipMin   = 11'd1093;      // >> 14, (x >> 2) / 15

  localparam int unsigned NumMonths = 12;

  // first day of year of each month
  localparam logic [8:0] MonStartLeap [NumMonths] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };
  localparam logic [8:0] MonStartNorm [NumMonths] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // whole days since the epoch and second of day
  typedef struct packed {
    logic        neg;
    logic [14:0] days;
    logic [16:0] sod;
  } e2c_split_t;

endpackage

// ===== hw/rtl/e2c_day_split.sv =====
// e2c_day_split: three-stage split of epoch seconds into days and second of day
// depends on e2c_pkg; one transaction per cycle while adv is high, advanced by the top level
module e2c_day_split
  import e2c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic signed [31:0] in_secs,
  output logic              out_valid,
  output e2c_split_t        out_data
);

  // stage 1: multiply by reciprocal of 675
  logic        s1_valid_r;
  logic        s1_neg_r;
  logic [6:0]  s1_lo_r;
  logic [23:0] s1_x_r;
  logic [48:0] s1_prod_r;
  logic [23:0] s1_x_nxt;

  // stage 2: estimated quotient and remainder
  logic        s2_valid_r;
  logic        s2_neg_r;
  logic [6:0]  s2_lo_r;
  logic [14:0] s2_q_r;
  logic [10:0] s2_rem_r;
  logic [14:0] s2_q_nxt;
  logic [23:0] s2_diff;

  // stage 3: corrected result
  logic        s3_valid_r;
  e2c_split_t  s3_data_r;
  e2c_split_t  s3_data_nxt;
  logic        s3_fix;
  logic [10:0] s3_rem;

  assign s1_x_nxt = in_secs[30:DayLowBits];
  assign s2_q_nxt = s1_prod_r[48:34];
  assign s2_diff  = s1_x_r - 24'(s2_q_nxt * 10'(DayOdd));

  always_comb begin
    s3_fix           = s2_rem_r >= 11'(DayOdd);
    s3_rem           = s3_fix ? (s2_rem_r - 11'(DayOdd)) : s2_rem_r;
    s3_data_nxt.neg  = s2_neg_r;
    s3_data_nxt.days = s3_fix ? (s2_q_r + 15'd1) : s2_q_r;
    s3_data_nxt.sod  = {s3_rem[9:0], s2_lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r  <= in_secs[31];
      s1_lo_r   <= in_secs[DayLowBits-1:0];
      s1_x_r    <= s1_x_nxt;
      s1_prod_r <= 49'(s1_x_nxt) * 49'(RecipOdd);
      s2_neg_r  <= s1_neg_r;
      s2_lo_r   <= s1_lo_r;
      s2_q_r    <= s2_q_nxt;
      s2_rem_r  <= s2_diff[10:0];
      s3_data_r <= s3_data_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_data_r;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// epoch_seconds_to_calendar: signed epoch seconds to broken-down UTC time
// depends on e2c_pkg and e2c_day_split
//
// Input channel: in_valid / in_stall with in_epoch_seconds, a two's
// complement count of seconds since 1970-01-01 00:00:00 UTC. Output channel:
// out_valid / out_stall with the calendar fields. A negative input yields
// out_valid_res low and all other fields zero.
// A transaction moves at an edge where valid is high and stall is low.
// A new transaction can be accepted every cycle while the output is not
// stalled, so throughput is one per cycle. The pipeline has seven register
// stages (three for the day split, four for year, month, weekday and time
// of day), each about one constant multiply or compare chain deep.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or duplicated.
// Synchronous active-low reset clears all stage valid bits; payload registers
// are not reset.
module epoch_seconds_to_calendar
  import e2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic [7:0]         out_year_since_1900,
  output logic [8:0]         out_day_of_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [2:0]         out_weekday,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  logic       adv;
  logic       sp_valid;
  e2c_split_t sp_data;

  // stage 4: reciprocal products
  logic        s4_valid_r;
  logic        s4_neg_r;
  logic [14:0] s4_days_r;
  logic [14:0] s4_d4_r;
  logic [16:0] s4_sod_r;
  logic [30:0] s4_pq_r;
  logic [29:0] s4_pw_r;
  logic [24:0] s4_ph_r;
  logic [14:0] s4_d4_nxt;

  // stage 5: quad split, weekday, hour
  logic        s5_valid_r;
  logic        s5_neg_r;
  logic [4:0]  s5_quads_r;
  logic [10:0] s5_diq_r;
  logic [2:0]  s5_wday_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_remh_r;
  logic [4:0]  s5_quads_nxt;
  logic [11:0] s5_q7_nxt;
  logic [4:0]  s5_hour_nxt;
  logic [14:0] s5_diq_full;
  logic [14:0] s5_wd_full;
  logic [16:0] s5_remh_full;

  // stage 6: year within quad, minute product
  logic        s6_valid_r;
  logic        s6_neg_r;
  logic [7:0]  s6_year_r;
  logic [8:0]  s6_yday_r;
  logic        s6_leap_r;
  logic [2:0]  s6_wday_r;
  logic [4:0]  s6_hour_r;
  logic [11:0] s6_remh_r;
  logic [19:0] s6_pm_r;
  logic [1:0]  s6_yiq_nxt;
  logic [10:0] s6_base_nxt;
  logic [10:0] s6_yday_full;
  logic [7:0]  s6_year_nxt;

  // output stage
  logic        out_valid_r;
  logic        res_r;
  logic [7:0]  year_r;
  logic [8:0]  yday_r;
  logic [3:0]  mon_r;
  logic [4:0]  mday_r;
  logic [2:0]  wday_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [3:0]  mon_nxt;
  logic [8:0]  mstart_nxt;
  logic [8:0]  mday_full;
  logic [5:0]  min_nxt;
  logic [11:0] sec_full;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  e2c_day_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_secs   (in_epoch_seconds),
    .out_valid (sp_valid),
    .out_data  (sp_data)
  );

  assign s4_d4_nxt = sp_data.days + 15'(EpochWday);

  always_comb begin
    s5_quads_nxt = s4_pq_r[30:26];
    s5_q7_nxt    = s4_pw_r[29:18];
    s5_hour_nxt  = s4_ph_r[24:20];
    s5_diq_full  = s4_days_r - 15'(s5_quads_nxt * 11'(DaysQuad));
    s5_wd_full   = s4_d4_r - 15'(s5_q7_nxt * 3'd7);
    s5_remh_full = s4_sod_r - 17'(s5_hour_nxt * 12'(SecsHour));
  end

  // year within the four-year interval; the third year is the leap one
  always_comb begin
    priority if (s5_diq_r < 11'(DaysYear)) begin
      s6_yiq_nxt  = 2'd0;
      s6_base_nxt = 11'd0;
    end else if (s5_diq_r < 11'(2 * DaysYear)) begin
      s6_yiq_nxt  = 2'd1;
      s6_base_nxt = 11'(DaysYear);
    end else if (s5_diq_r < 11'(3 * DaysYear + 1)) begin
      s6_yiq_nxt  = 2'd2;
      s6_base_nxt = 11'(2 * DaysYear);
    end else begin
      s6_yiq_nxt  = 2'd3;
      s6_base_nxt = 11'(3 * DaysYear + 1);
    end
    s6_yday_full = s5_diq_r - s6_base_nxt;
    s6_year_nxt  = 8'(EpochYear) + {1'b0, s5_quads_r, 2'b00} + 8'(s6_yiq_nxt);
  end

  // month by comparing against each month start
  always_comb begin
    mon_nxt = 4'd0;
    for (int k = 1; k < NumMonths; k++) begin
      if (s6_leap_r ? (s6_yday_r >= MonStartLeap[k]) : (s6_yday_r >= MonStartNorm[k]))
        mon_nxt = 4'(k);
    end
    mstart_nxt = s6_leap_r ? MonStartLeap[mon_nxt] : MonStartNorm[mon_nxt];
    mday_full  = s6_yday_r - mstart_nxt + 9'd1;
    min_nxt    = s6_pm_r[19:14];
    sec_full   = s6_remh_r - 12'(min_nxt * 6'(SecsMin));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r  <= sp_valid;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg_r   <= sp_data.neg;
      s4_days_r  <= sp_data.days;
      s4_d4_r    <= s4_d4_nxt;
      s4_sod_r   <= sp_data.sod;
      s4_pq_r    <= 31'(sp_data.days) * 31'(RecipQuad);
      s4_pw_r    <= 30'(30'(s4_d4_nxt) * 30'(RecipSeven));
      s4_ph_r    <= 25'(25'(sp_data.sod[16:4]) * 25'(RecipHour));

      s5_neg_r   <= s4_neg_r;
      s5_quads_r <= s5_quads_nxt;
      s5_diq_r   <= s5_diq_full[10:0];
      s5_wday_r  <= s5_wd_full[2:0];
      s5_hour_r  <= s5_hour_nxt;
      s5_remh_r  <= s5_remh_full[11:0];

      s6_neg_r   <= s5_neg_r;
      s6_year_r  <= s6_year_nxt;
      s6_yday_r  <= s6_yday_full[8:0];
      s6_leap_r  <= (s6_yiq_nxt == 2'd2);
      s6_wday_r  <= s5_wday_r;
      s6_hour_r  <= s5_hour_r;
      s6_remh_r  <= s5_remh_r;
      s6_pm_r    <= 20'(s5_remh_r[11:2]) * 20'(RecipMin);

      // negative input clears every field
      res_r  <= !s6_neg_r;
      year_r <= s6_neg_r ? 8'd0 : s6_year_r;
      yday_r <= s6_neg_r ? 9'd0 : s6_yday_r;
      mon_r  <= s6_neg_r ? 4'd0 : mon_nxt;
      mday_r <= s6_neg_r ? 5'd0 : mday_full[4:0];
      wday_r <= s6_neg_r ? 3'd0 : s6_wday_r;
      hour_r <= s6_neg_r ? 5'd0 : s6_hour_r;
      min_r  <= s6_neg_r ? 6'd0 : min_nxt;
      sec_r  <= s6_neg_r ? 6'd0 : sec_full[5:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_valid_res       = res_r;
  assign out_year_since_1900 = year_r;
  assign out_day_of_year     = yday_r;
  assign out_month           = mon_r;
  assign out_day_of_month    = mday_r;
  assign out_weekday         = wday_r;
  assign out_hour            = hour_r;
  assign out_minute          = min_r;
  assign out_second          = sec_r;

  // time of day digits stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r |-> hour_r < 5'd24 && min_r < 6'd60 && sec_r < 6'd60)
    else $error("time of day out of range");

  // date fields consistent with the year split
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r |-> mon_r < 4'd12 && mday_r != 5'd0 && yday_r <= 9'd365
      && year_r >= 8'd70 && year_r <= 8'd138 && wday_r < 3'd7)
    else $error("calendar field out of range");

  // rejected input yields an all-zero result
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r |-> year_r == 8'd0 && yday_r == 9'd0 && mon_r == 4'd0
      && mday_r == 5'd0 && wday_r == 3'd0 && hour_r == 5'd0 && min_r == 6'd0
      && sec_r == 6'd0)
    else $error("negative input result not cleared");

  // a held output freezes the pipeline
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(s6_valid_r) && $stable(s4_valid_r)
      && $stable(sp_valid))
    else $error("pipeline moved during output stall");

endmodule
